// ===== rtl/dxt3_pkg.sv =====
// Shared types and constants for the DXT3 block decoder.
package dxt3_pkg;

   // Configuration port
   localparam int unsigned CFG_W     = 15;
   localparam int unsigned CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   // Image dimensions
   localparam int unsigned MAX_DIM_DEFAULT = 16384;
   localparam int unsigned DIM_RESET       = 16384;

   // Pixel coordinate width on the result side
   localparam int unsigned PIX_W = 14;

   // Stream payload widths
   localparam int unsigned REQ_DATA_W = 128;
   localparam int unsigned RSP_DATA_W = 64;

   // Block queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // One classified block, ready for pixel emission
   typedef struct packed {
      logic [63:0]          alpha_bits;
      logic [31:0]          indices;
      rgb_type [3:0]        palette;
      logic [15:0]          mask;
      logic [PIX_W-1:0]     x0;
      logic [PIX_W-1:0]     y0;
   } blk_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== rtl/dxt3_front.sv =====
// Front end: config registers, block position, clip mask and palette build.
module dxt3_front #(
   parameter int unsigned MAX_DIM = dxt3_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dxt3_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dxt3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dxt3_pkg::CFG_W-1:0]        csr_wdata,
   input  dxt3_pkg::q_stat_type              q_stat,
   output logic                              q_push,
   output dxt3_pkg::blk_type                 q_blk
);
   import dxt3_pkg::*;

   localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
   localparam int unsigned COL_W = (((MAX_DIM + 3) / 4) > 1) ? $clog2((MAX_DIM + 3) / 4) : 1;
   localparam int unsigned POS_W = ((COL_W + 3) > (DIM_W + 1)) ? (COL_W + 3) : (DIM_W + 1);
   localparam int unsigned CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
   localparam int unsigned RESET_DIM = (DIM_RESET < MAX_DIM) ? DIM_RESET : MAX_DIM;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] row_ff, row_in;
   logic [COL_W:0]   col_inc, row_inc;
   logic             col_wrap, row_wrap;
   logic [POS_W-1:0] x0_pos, y0_pos;
   logic [3:0]       col_ok, row_ok;
   logic [15:0]      mask;
   logic [31:0]      x0_wide, y0_wide;
   logic             req_xfer;
   rgb_type          end0, end1;

   // zero reads as one, anything past the limit as the limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (ext == '0)
         clamp_dim = DIM_W'(1);
      else if (ext > CMP_W'(MAX_DIM))
         clamp_dim = DIM_W'(MAX_DIM);
      else
         clamp_dim = DIM_W'(ext);
   endfunction

   function automatic rgb_type expand565(input logic [15:0] e);
      rgb_type c;
      c.red   = {e[15:11], 3'b000};
      c.green = {e[10:5], 2'b00};
      c.blue  = {e[4:0], 3'b000};
      return c;
   endfunction

   // round((2a + b) / 3): divide by 3 through multiply by 683 >> 11 (exact below 768)
   function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
      logic [9:0]  num;
      logic [19:0] prod;
      num  = {1'b0, a, 1'b0} + {2'b00, b} + 10'd1;
      prod = 20'(num) * 20'd683;
      return prod[18:11];
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = !q_stat.full;
   assign req_xfer   = req_tvalid && req_tready;

   // next block position
   always_comb begin
      col_inc  = {1'b0, col_ff} + (COL_W + 1)'(1);
      row_inc  = {1'b0, row_ff} + (COL_W + 1)'(1);
      col_wrap = POS_W'({col_inc, 2'b00}) >= POS_W'(width_ff);
      row_wrap = POS_W'({row_inc, 2'b00}) >= POS_W'(height_ff);
      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : row_inc[COL_W-1:0];
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = row_ff;
      end
   end

   // clip mask, raster order inside the block
   always_comb begin
      x0_pos = POS_W'({col_ff, 2'b00});
      y0_pos = POS_W'({row_ff, 2'b00});
      for (int i = 0; i < 4; i++) begin
         col_ok[i] = (x0_pos + POS_W'(i)) < POS_W'(width_ff);
         row_ok[i] = (y0_pos + POS_W'(i)) < POS_W'(height_ff);
      end
      for (int j = 0; j < 4; j++) begin
         for (int i = 0; i < 4; i++) begin
            mask[4*j + i] = col_ok[i] && row_ok[j];
         end
      end
      x0_wide = 32'(x0_pos);
      y0_wide = 32'(y0_pos);
   end

   always_comb begin
      end0 = expand565(req_tdata[79:64]);
      end1 = expand565(req_tdata[95:80]);
      q_blk.alpha_bits       = req_tdata[63:0];
      q_blk.indices          = req_tdata[127:96];
      q_blk.palette[0]       = end0;
      q_blk.palette[1]       = end1;
      q_blk.palette[2].red   = third(end0.red, end1.red);
      q_blk.palette[2].green = third(end0.green, end1.green);
      q_blk.palette[2].blue  = third(end0.blue, end1.blue);
      q_blk.palette[3].red   = third(end1.red, end0.red);
      q_blk.palette[3].green = third(end1.green, end0.green);
      q_blk.palette[3].blue  = third(end1.blue, end0.blue);
      q_blk.mask             = mask;
      q_blk.x0               = x0_wide[PIX_W-1:0];
      q_blk.y0               = y0_wide[PIX_W-1:0];
   end

   // fully clipped blocks only move the position
   assign q_push = req_xfer && (mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(RESET_DIM);
         height_ff <= DIM_W'(RESET_DIM);
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_ff <= clamp_dim(csr_wdata);
               col_ff   <= '0;
               row_ff   <= '0;
            end
            REG_IMAGE_HEIGHT: begin
               height_ff <= clamp_dim(csr_wdata);
               col_ff    <= '0;
               row_ff    <= '0;
            end
            default: ;
         endcase
      end else if (req_xfer) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== rtl/dxt3_queue.sv =====
// Short block queue between the front end and the pixel emitter.
module dxt3_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dxt3_pkg::blk_type    push_blk,
   input  logic                 pop,
   output dxt3_pkg::blk_type    pop_blk,
   output dxt3_pkg::q_stat_type stat
);
   import dxt3_pkg::*;

   blk_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1))
         return '0;
      else
         return p + PTR_W'(1);
   endfunction

   assign stat.full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign stat.empty = count_ff == '0;
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_blk    = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_blk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= ptr_next(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= ptr_next(rd_ptr_ff);
         if (do_push && !do_pop)
            count_ff <= count_ff + CNT_W'(1);
         else if (do_pop && !do_push)
            count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

// ===== rtl/dxt3_back.sv =====
// Back end: walks the pixel mask, one pixel per cycle unless stalled.
module dxt3_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  dxt3_pkg::blk_type                 q_blk,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dxt3_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              busy
);
   import dxt3_pkg::*;

   blk_type          cur_ff;
   logic [15:0]      rem_ff, rem_after;
   logic [3:0]       k;
   logic [1:0]       sel;
   logic [3:0]       nib;
   logic             advance, emit;
   logic             rsp_valid_ff;
   logic [7:0]       red_ff, green_ff, blue_ff, alpha_ff;
   logic [PIX_W-1:0] x_ff, y_ff;
   logic             last_ff;

   // lowest pending pixel
   always_comb begin
      k = '0;
      for (int b = 15; b >= 0; b--) begin
         if (rem_ff[b]) k = 4'(b);
      end
      rem_after = rem_ff & ~(16'd1 << k);
      sel       = cur_ff.indices[{k, 1'b0} +: 2];
      nib       = cur_ff.alpha_bits[{k, 2'b00} +: 4];
   end

   assign advance = !rsp_valid_ff || rsp_tready;
   assign emit    = advance && (rem_ff != '0);
   // load a block when idle or as the current one emits its last pixel
   assign q_pop   = q_valid && ((rem_ff == '0) || (emit && (rem_after == '0)));
   assign busy    = rem_ff != '0;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_blk;
      end
      if (emit) begin
         red_ff   <= cur_ff.palette[sel].red;
         green_ff <= cur_ff.palette[sel].green;
         blue_ff  <= cur_ff.palette[sel].blue;
         alpha_ff <= {nib, nib};
         x_ff     <= cur_ff.x0 + PIX_W'(k[1:0]);
         y_ff     <= cur_ff.y0 + PIX_W'(k[3:2]);
         last_ff  <= rem_after == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop)
            rem_ff <= q_blk.mask;
         else if (emit)
            rem_ff <= rem_after;
         if (advance)
            rsp_valid_ff <= emit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {4'b0000, y_ff, x_ff, alpha_ff, blue_ff, green_ff, red_ff};

endmodule

// ===== rtl/dxt3_block_decoder.sv =====
// DXT3 (BC2) block decoder top level: front end, block queue, pixel emitter.
//
//   channel  dir  handshake                 payload
//   req      in   req_tvalid/req_tready     req_tdata: alpha_bits, color_bits
//   rsp      out  rsp_tvalid/rsp_tready     rsp_tdata: rgba, pixel_x, pixel_y; rsp_tlast
//   csr      in   csr_valid/csr_ready       csr_index, csr_wdata
//
// The emitter sends one pixel for each of a block's pixels inside the image: 16 for an
// interior block, fewer at the right and bottom edges, none for a block wholly outside.
// While rsp_tready holds, the emitter's one pixel per cycle sets the sustained rate.
// Front and back meet at a two-entry queue, so the next block is taken while the
// current one drains, and the output register holds a pixel under rsp stall. Reset is
// synchronous; it restores full-size dimensions and block position zero.
module dxt3_block_decoder #(
   parameter int unsigned MAX_DIM = dxt3_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // [63:0] alpha_bits, [127:64] color_bits
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dxt3_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
   // [45:32] pixel_x, [59:46] pixel_y, [63:60] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dxt3_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   // register 0 image_width, register 1 image_height
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dxt3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dxt3_pkg::CFG_W-1:0]        csr_wdata
);
   import dxt3_pkg::*;

   q_stat_type q_stat;
   blk_type    push_blk, pop_blk;
   logic       q_push, q_pop;
   logic       back_busy;

   dxt3_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_blk      (push_blk)
   );

   dxt3_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_blk (push_blk),
      .pop      (q_pop),
      .pop_blk  (pop_blk),
      .stat     (q_stat)
   );

   dxt3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (!q_stat.empty),
      .q_blk      (pop_blk),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .busy       (back_busy)
   );

   // a block is never pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("block pushed into full queue");

   // a pixel not marked last leaves more pixels of its block pending
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> back_busy)
      else $error("non-last pixel with no pixels pending");

   // a block is popped mid-block only when the output advances and the queue holds one
   a_pop_done: assert property (@(posedge clock) disable iff (reset)
      (q_pop && back_busy) |-> (rsp_tvalid == 1'b0 || rsp_tready) ##0 (!q_stat.empty))
      else $error("queue popped while block in progress and stalled");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// ===== verif/dxt3_block_decoder_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the DXT3 block decoder: tracks the block walk, predicts pixels, compares.
module dxt3_block_decoder_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [dxt3_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [dxt3_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tlast,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [dxt3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dxt3_pkg::CFG_W-1:0]        csr_wdata,
   output int                                mismatches,
   output int                                outstanding
);

   localparam int PW = dxt3_pkg::PIX_W;
   localparam int CW = dxt3_pkg::CFG_W;

   typedef struct packed {
      logic [7:0]    red;
      logic [7:0]    green;
      logic [7:0]    blue;
      logic [7:0]    alpha;
      logic [PW-1:0] px;
      logic [PW-1:0] py;
      logic          last;
   } pixel_type;

   logic [dxt3_pkg::CFG_W-1:0] width_reg;
   logic [dxt3_pkg::CFG_W-1:0] height_reg;
   int unsigned                blk_col;
   int unsigned                blk_row;
   pixel_type                  pixels_due[$];

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input pixel_type want,
                              input logic [31:0] got, input logic [31:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s at (%0d,%0d): got %0h, want %0h",
                                   name, want.px, want.py, got, exp_val));
   endtask

   // 0 behaves as 1, anything past the maximum as the maximum
   function automatic int unsigned clamp_dim(input logic [dxt3_pkg::CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > dxt3_pkg::MAX_DIM_DEFAULT) return dxt3_pkg::MAX_DIM_DEFAULT;
      return v;
   endfunction

   task automatic decode_block(input logic [63:0] abits, input logic [63:0] cbits);
      int unsigned pal [4][3];
      int unsigned w, h, x0, y0, i, j, c, k, n;
      logic [1:0]  sel;
      logic [3:0]  nib;
      pixel_type   blk_px [16];
      w  = clamp_dim(width_reg);
      h  = clamp_dim(height_reg);
      x0 = blk_col * 4;
      y0 = blk_row * 4;
      n  = 0;
      pal[0][0] = {cbits[15:11], 3'b000};
      pal[0][1] = {cbits[10:5], 2'b00};
      pal[0][2] = {cbits[4:0], 3'b000};
      pal[1][0] = {cbits[31:27], 3'b000};
      pal[1][1] = {cbits[26:21], 2'b00};
      pal[1][2] = {cbits[20:16], 3'b000};
      for (c = 0; c < 3; c++) begin
         pal[2][c] = (2 * pal[0][c] + pal[1][c] + 1) / 3;
         pal[3][c] = (pal[0][c] + 2 * pal[1][c] + 1) / 3;
      end
      for (j = 0; j < 4; j++) begin
         for (i = 0; i < 4; i++) begin
            if (x0 + i < w && y0 + j < h) begin
               k   = j * 4 + i;
               sel = cbits[32 + 2 * k +: 2];
               nib = abits[16 * j + 4 * i +: 4];
               blk_px[n].red   = 8'(pal[sel][0]);
               blk_px[n].green = 8'(pal[sel][1]);
               blk_px[n].blue  = 8'(pal[sel][2]);
               blk_px[n].alpha = {nib, nib};
               blk_px[n].px    = PW'(x0 + i);
               blk_px[n].py    = PW'(y0 + j);
               blk_px[n].last  = 1'b0;
               n++;
            end
         end
      end
      if (n > 0) blk_px[n - 1].last = 1'b1;
      for (k = 0; k < n; k++) pixels_due.push_back(blk_px[k]);
      // raster walk over blocks, wrapping at the right and bottom edges
      blk_col++;
      if (blk_col * 4 >= w) begin
         blk_col = 0;
         blk_row++;
         if (blk_row * 4 >= h) blk_row = 0;
      end
   endtask

   task automatic check_pixel();
      pixel_type want;
      if (pixels_due.size() == 0) begin
         report_mismatch($sformatf("pixel with nothing pending: %h", rsp_tdata));
      end else begin
         want = pixels_due.pop_front();
         check_field("red",     want, rsp_tdata[7:0],   want.red);
         check_field("green",   want, rsp_tdata[15:8],  want.green);
         check_field("blue",    want, rsp_tdata[23:16], want.blue);
         check_field("alpha",   want, rsp_tdata[31:24], want.alpha);
         check_field("pixel_x", want, rsp_tdata[45:32], want.px);
         check_field("pixel_y", want, rsp_tdata[59:46], want.py);
         check_field("pad",     want, rsp_tdata[63:60], '0);
         check_field("last",    want, rsp_tlast,        want.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = CW'(dxt3_pkg::DIM_RESET);
         height_reg = CW'(dxt3_pkg::DIM_RESET);
         blk_col    = 0;
         blk_row    = 0;
         mismatches = 0;
         pixels_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_pixel();
         if (csr_valid && csr_ready) begin
            if (csr_index == dxt3_pkg::REG_IMAGE_WIDTH) begin
               width_reg = csr_wdata;
               blk_col   = 0;
               blk_row   = 0;
            end else if (csr_index == dxt3_pkg::REG_IMAGE_HEIGHT) begin
               height_reg = csr_wdata;
               blk_col    = 0;
               blk_row    = 0;
            end
         end
         if (req_tvalid && req_tready) decode_block(req_tdata[63:0], req_tdata[127:64]);
      end
      outstanding = pixels_due.size();
   end

endmodule

// ===== verif/dxt3_block_decoder_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the DXT3 block decoder: clock, reset, stimulus and verdict.
module dxt3_block_decoder_tb;

   localparam int LIMIT_CYCLES = 200000;
   localparam int QUIET_CYCLES = 40;    // front end + two-entry queue + 16-pixel drain
   localparam int HOLD_CYCLES  = 300;   // receiver back-pressure stretch
   localparam int ITEMS_PER_PHASE = 25;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   // [63:0] alpha_bits, [127:64] color_bits
   logic [dxt3_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
   // [45:32] pixel_x, [59:46] pixel_y, [63:60] zero
   logic [dxt3_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              rsp_tlast;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [dxt3_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [dxt3_pkg::CFG_W-1:0]        csr_wdata;

   int   mismatches;
   int   outstanding;
   int   cycle_count;
   logic calm;      // no idling on either side while set
   logic hold_go;   // asks the receiver for one long hold-off

   dxt3_block_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   dxt3_block_decoder_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hang or a lost pixel ends here.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Receiver: random stalls, a stall-free stretch, and one long hold-off
   // so the block backs up into its queue and drops req_tready.
   initial begin
      logic hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 31);
            @(negedge clock);
         end
      end
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly random, sometimes flat alpha
   function automatic logic [63:0] pick_alpha_word();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return rand_word();
      endcase
   endfunction

   // Mostly random, sometimes equal endpoints, an all-ones word or zero endpoints
   function automatic logic [63:0] pick_color_word();
      logic [15:0] ep;
      ep = 16'($urandom);
      case ($urandom_range(15))
         0, 1:    return {32'($urandom), ep, ep};
         2:       return '1;
         3:       return {32'($urandom), 32'h0};
         default: return rand_word();
      endcase
   endfunction

   // One block transfer; entered and left at a falling edge, valid stays high on return.
   task automatic send_block(input logic [63:0] abits, input logic [63:0] cbits);
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cbits, abits};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Register writes only with the block drained and quiet.
   task automatic write_csr(input logic [dxt3_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dxt3_pkg::CFG_W-1:0] value);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase;
      logic [dxt3_pkg::CFG_W-1:0] w, h;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = dxt3_pkg::REG_IMAGE_WIDTH;
      csr_wdata  = '0;
      calm       = 1'b0;
      hold_go    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full-size image after reset: palette corner cases.
      send_block('0, '0);
      send_block('1, '1);
      // red vs blue endpoints, indices 0..3 across each row, every alpha nibble
      send_block(64'hFEDC_BA98_7654_3210, {32'hE4E4_E4E4, 16'h001F, 16'hF800});
      // equal endpoints: thirds collapse onto the endpoint
      send_block(64'h0F0F_F0F0_5A5A_A5A5, {32'h1B1B_1B1B, 16'h7BEF, 16'h7BEF});
      // black/white endpoints with all-two indices, then green endpoints with all-three indices
      send_block(64'h8888_4444_2222_1111, {32'hAAAA_AAAA, 16'hFFFF, 16'h0000});
      send_block(64'hFFFF_0000_FFFF_0000, {32'hFFFF_FFFF, 16'h0020, 16'h07E0});
      send_block(rand_word(), {32'h5555_5555, 16'h0821, 16'hF7DE});

      // 5x6: right and bottom clipping, then wrap back to the first block
      write_csr(dxt3_pkg::REG_IMAGE_WIDTH, 15'd5);
      write_csr(dxt3_pkg::REG_IMAGE_HEIGHT, 15'd6);
      repeat (5) send_block(rand_word(), rand_word());

      // zero dimensions act as one pixel
      write_csr(dxt3_pkg::REG_IMAGE_WIDTH, 15'd0);
      write_csr(dxt3_pkg::REG_IMAGE_HEIGHT, 15'd0);
      repeat (2) send_block(rand_word(), rand_word());

      // oversize width clamps to the maximum; three-row strip
      write_csr(dxt3_pkg::REG_IMAGE_WIDTH, 15'h7FFF);
      write_csr(dxt3_pkg::REG_IMAGE_HEIGHT, 15'd3);
      repeat (3) send_block(rand_word(), rand_word());

      // column wrap on a 7-wide image at full height
      write_csr(dxt3_pkg::REG_IMAGE_WIDTH, 15'd7);
      write_csr(dxt3_pkg::REG_IMAGE_HEIGHT, 15'd16384);
      repeat (3) send_block(rand_word(), rand_word());

      // Random phases, each with its own image size.
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               w = 15'd16384;
               h = 15'd9;
            end
            1: begin
               w = 15'($urandom_range(12, 1));
               h = 15'($urandom_range(12, 1));
            end
            3: begin
               w = 15'($urandom_range(3, 0));
               h = 15'($urandom_range(40, 0));
            end
            6: begin
               w = 15'h7FFF;
               h = 15'h7FFF;
            end
            default: begin
               w = 15'($urandom_range(40, 0));
               h = 15'($urandom_range(40, 0));
            end
         endcase
         // phase 5 rewrites only the height; that alone must rewind the walk
         if (phase != 5) write_csr(dxt3_pkg::REG_IMAGE_WIDTH, w);
         write_csr(dxt3_pkg::REG_IMAGE_HEIGHT, h);
         calm = (phase == 2);
         if (phase == 4) hold_go = 1'b1;
         repeat (ITEMS_PER_PHASE) send_block(pick_alpha_word(), pick_color_word());
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then give stray pixels time to show up
      while (outstanding != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dxt3_pkg.sv
rtl/dxt3_front.sv
rtl/dxt3_queue.sv
rtl/dxt3_back.sv
rtl/dxt3_block_decoder.sv
verif/dxt3_block_decoder_checker.sv
verif/dxt3_block_decoder_tb.sv
